>>> hdl/wtc_pkg.sv
// shared types, codes and constants of the whitespace tokenizer
package wtc_pkg;

    // default counter widths
    localparam int LINE_BITS_DEF   = 24;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;

    // result queue depth, room for two records per input beat
    localparam int FIFO_DEPTH = 4;

    // input beat kinds carried on s_tuser
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_EOF  = 1'b1;

    // register index of first_line_number
    localparam logic REG_FIRST_LINE = 1'b0;

    // record kinds carried on m_tuser
    localparam logic [1:0] KIND_TOKEN = 2'd0;
    localparam logic [1:0] KIND_EOL   = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;

    // characters with a meaning to the scanner
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_NL   = 8'h0A;
    localparam logic [7:0] CHAR_SP   = 8'h20;
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;

    // configuration write toward the scanner
    typedef struct packed {
        logic wr;
        logic first_line;
    } cfg_t;

    // whitespace class of a byte
    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SP) || (b == CHAR_TAB) || (b == CHAR_NL) ||
               (b == CHAR_VT) || (b == CHAR_FF) || (b == CHAR_CR);
    endfunction

endpackage

>>> hdl/whitespace_tokenizer_with_comments_unit.sv
// top level: stream ports, register port, scanner and result queue
// a record can be taken from the result port in the cycle after the beat that causes it
// throughput: one input beat per cycle while the result queue has room; a beat causing
//   two records pushes both at once, and the four-entry result queue absorbs the difference
// reset: synchronous active-low aresetn clears scanner counters to zero, line
//   counter and first_line_number to one, and empties the result queue
module whitespace_tokenizer_with_comments_unit #(
    parameter int LINE_BITS   = wtc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = wtc_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = wtc_pkg::OFFSET_BITS_DEF,
    localparam int DATA_W     = LINE_BITS + 2 * COLUMN_BITS + OFFSET_BITS,
    localparam int TDATA_W    = ((DATA_W + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input beats
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // byte_in
    input  logic               s_tuser,   // action
    // result records
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // line_number, column, token_offset,
                                          // token_length, zero fill
    output logic [1:0]         m_tuser,   // kind
    output logic               m_tlast,   // last_of_run
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int REC_W = DATA_W + 3;

    logic             beat;
    logic             room;
    logic             first_line;
    wtc_pkg::cfg_t    cfg;
    logic [1:0]       rec_count;
    logic [REC_W-1:0] rec0, rec1, out_rec;

    // handshakes and register decode
    assign s_tready   = room;
    assign beat       = s_tvalid && room;
    assign pready     = 1'b1;
    assign cfg.wr     = psel && penable && pwrite && (paddr[2] == wtc_pkg::REG_FIRST_LINE);
    assign cfg.first_line = pwdata[0];
    assign prdata     = (paddr[2] == wtc_pkg::REG_FIRST_LINE) ? {31'd0, first_line} : 32'd0;

    wtc_scan #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .REC_W       (REC_W)
    ) u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beat       (beat),
        .action     (s_tuser),
        .byte_in    (s_tdata),
        .cfg        (cfg),
        .first_line (first_line),
        .rec_count  (rec_count),
        .rec0       (rec0),
        .rec1       (rec1)
    );

    wtc_fifo #(
        .REC_W (REC_W)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (rec_count),
        .push0      (rec0),
        .push1      (rec1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rec    (out_rec)
    );

    // unpack the record onto the result beat
    assign m_tdata = TDATA_W'(out_rec[DATA_W-1:0]);
    assign m_tuser = out_rec[REC_W-2 -: 2];
    assign m_tlast = out_rec[REC_W-1];

endmodule

>>> hdl/wtc_scan.sv
// scanner state and per-beat record generation
module wtc_scan #(
    parameter int LINE_BITS   = wtc_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = wtc_pkg::COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = wtc_pkg::OFFSET_BITS_DEF,
    parameter int REC_W       = LINE_BITS + 2 * COLUMN_BITS + OFFSET_BITS + 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat,
    input  logic               action,
    input  logic [7:0]         byte_in,
    input  wtc_pkg::cfg_t      cfg,
    output logic               first_line,
    output logic [1:0]         rec_count,
    output logic [REC_W-1:0]   rec0,
    output logic [REC_W-1:0]   rec1
);

    localparam int BODY_W = REC_W - 1;
    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);
    localparam logic [OFFSET_BITS-1:0] OFF_ONE  = OFFSET_BITS'(1);

    typedef enum logic [1:0] {
        MODE_BETWEEN = 2'd0,
        MODE_TOKEN   = 2'd1,
        MODE_COMMENT = 2'd2
    } mode_t;

    mode_t                  mode_reg, mode_next;
    logic                   first_line_reg, first_line_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] tok_off_reg, tok_off_next;
    logic [COLUMN_BITS-1:0] tok_col_reg, tok_col_next;
    logic [COLUMN_BITS-1:0] tok_len_reg, tok_len_next;

    logic [COLUMN_BITS-1:0] pos_inc;
    logic [BODY_W-1:0]      body_tok, body_eol, body_eof;
    logic [BODY_W-1:0]      body0, body1;
    logic                   nl, sp;

    // saturating column increment and the three record bodies
    always_comb begin
        pos_inc  = (pos_reg == '1) ? pos_reg : pos_reg + COL_ONE;
        body_tok = {wtc_pkg::KIND_TOKEN, tok_len_reg, tok_off_reg, tok_col_reg, line_reg};
        body_eol = {wtc_pkg::KIND_EOL, {COLUMN_BITS{1'b0}}, {OFFSET_BITS{1'b0}},
                    pos_inc, line_reg};
        body_eof = {wtc_pkg::KIND_EOF, {COLUMN_BITS{1'b0}}, {OFFSET_BITS{1'b0}},
                    pos_reg, line_reg};
        nl = (byte_in == wtc_pkg::CHAR_NL);
        sp = wtc_pkg::is_space(byte_in);
    end

    // next state and records for one accepted beat
    always_comb begin
        mode_next       = mode_reg;
        first_line_next = first_line_reg;
        line_next       = line_reg;
        pos_next        = pos_reg;
        offset_next     = offset_reg;
        tok_off_next    = tok_off_reg;
        tok_col_next    = tok_col_reg;
        tok_len_next    = tok_len_reg;
        rec_count       = 2'd0;
        body0           = body_eof;
        body1           = body_eof;

        if (beat) begin
            if (action == wtc_pkg::ACT_EOF) begin
                // end of input flushes an open token, counters stay
                if (mode_reg == MODE_TOKEN) begin
                    body0     = body_tok;
                    body1     = body_eof;
                    rec_count = 2'd2;
                end else begin
                    body0     = body_eof;
                    rec_count = 2'd1;
                end
                mode_next = MODE_BETWEEN;
            end else begin
                case (mode_reg)
                    MODE_TOKEN: begin
                        if (sp) begin
                            body0     = body_tok;
                            mode_next = MODE_BETWEEN;
                            if (nl) begin
                                body1     = body_eol;
                                rec_count = 2'd2;
                            end else begin
                                rec_count = 2'd1;
                            end
                        end else begin
                            tok_len_next = (tok_len_reg == '1) ? tok_len_reg
                                                               : tok_len_reg + COL_ONE;
                        end
                    end
                    MODE_COMMENT: begin
                        if (nl) begin
                            body0     = body_eol;
                            rec_count = 2'd1;
                            mode_next = MODE_BETWEEN;
                        end
                    end
                    default: begin
                        // between tokens, also the unused mode code
                        mode_next = MODE_BETWEEN;
                        if (nl) begin
                            body0     = body_eol;
                            rec_count = 2'd1;
                        end else if (sp) begin
                            mode_next = MODE_BETWEEN;
                        end else if (byte_in == wtc_pkg::CHAR_HASH) begin
                            mode_next = MODE_COMMENT;
                        end else begin
                            tok_off_next = offset_reg;
                            tok_col_next = pos_inc;
                            tok_len_next = COL_ONE;
                            mode_next    = MODE_TOKEN;
                        end
                    end
                endcase

                // position counters
                offset_next = (offset_reg == '1) ? offset_reg : offset_reg + OFF_ONE;
                if (nl) begin
                    line_next = (line_reg == '1) ? line_reg : line_reg + LINE_ONE;
                    pos_next  = '0;
                end else begin
                    pos_next = pos_inc;
                end
            end
        end

        // register write, loads the line counter before the first byte
        if (cfg.wr) begin
            first_line_next = cfg.first_line;
            if (offset_reg == '0) begin
                line_next = LINE_BITS'(cfg.first_line);
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_BETWEEN;
            first_line_reg <= 1'b1;
            line_reg       <= LINE_ONE;
            pos_reg        <= '0;
            offset_reg     <= '0;
            tok_off_reg    <= '0;
            tok_col_reg    <= '0;
            tok_len_reg    <= '0;
        end else begin
            mode_reg       <= mode_next;
            first_line_reg <= first_line_next;
            line_reg       <= line_next;
            pos_reg        <= pos_next;
            offset_reg     <= offset_next;
            tok_off_reg    <= tok_off_next;
            tok_col_reg    <= tok_col_next;
            tok_len_reg    <= tok_len_next;
        end
    end

    // last flag goes on the final record of the beat
    assign rec0       = {(rec_count == 2'd1), body0};
    assign rec1       = {1'b1, body1};
    assign first_line = first_line_reg;

endmodule

>>> hdl/wtc_fifo.sv
// small result queue taking up to two records per cycle
module wtc_fifo #(
    parameter int REC_W = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [1:0]       push_count,
    input  logic [REC_W-1:0] push0,
    input  logic [REC_W-1:0] push1,
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [REC_W-1:0] out_rec
);

    localparam int DEPTH = wtc_pkg::FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [REC_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // pointer and fill bookkeeping
    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // record storage
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem[wr_ptr_reg + PTR_W'(1)] <= push1;
        end
    end

    assign room      = (count_reg <= CNT_W'(DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_rec   = mem[rd_ptr_reg];

endmodule

>>> tb/whitespace_tokenizer_with_comments_unit_checker.sv
// checker for the tokenizer: predicts records from accepted beats and compares them
`timescale 1ns / 1ps

module whitespace_tokenizer_with_comments_unit_checker
    import wtc_pkg::*;
#(
    parameter int TDATA_W = 88
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [7:0]         s_tdata,   // byte_in
    input  logic               s_tuser,   // action
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // line_number, column, token_offset,
                                          // token_length, zero fill
    input  logic [1:0]         m_tuser,   // kind
    input  logic               m_tlast,   // last_of_run
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    output int                 pending,
    output int                 fail_count
);

    localparam int LINE_W = LINE_BITS_DEF;
    localparam int COL_W  = COLUMN_BITS_DEF;
    localparam int OFF_W  = OFFSET_BITS_DEF;

    // bit positions of the record fields in m_tdata
    localparam int COL_LSB = LINE_W;
    localparam int OFF_LSB = COL_LSB + COL_W;
    localparam int LEN_LSB = OFF_LSB + OFF_W;

    localparam int REPORT_MAX = 10;

    typedef enum logic [1:0] {
        SCAN_BETWEEN = 2'd0,
        SCAN_TOKEN   = 2'd1,
        SCAN_COMMENT = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic [OFF_W-1:0]  off;
        logic [COL_W-1:0]  len;
        logic              last;
    } record_t;

    // predicted scanner state
    logic              first_line;
    scan_mode_t        mode;
    logic [LINE_W-1:0] line_cnt;
    logic [COL_W-1:0]  line_pos;
    logic [OFF_W-1:0]  stream_pos;
    logic [OFF_W-1:0]  tok_off;
    logic [COL_W-1:0]  tok_col;
    logic [COL_W-1:0]  tok_len;

    record_t expected_records[$];
    int      errors = 0;

    // increment that sticks at the top of a counter of the given width
    function automatic logic [63:0] sat_bump(input logic [63:0] v, input int bits);
        logic [63:0] ceiling;
        ceiling = (64'd1 << bits) - 64'd1;
        return (v >= ceiling) ? ceiling : v + 64'd1;
    endfunction

    function automatic logic blank_byte(input logic [7:0] c);
        return c == CHAR_SP || c == CHAR_TAB || c == CHAR_NL || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    function automatic record_t token_record();
        return '{KIND_TOKEN, line_cnt, tok_col, tok_off, tok_len, 1'b0};
    endfunction

    function automatic record_t eol_record();
        return '{KIND_EOL, line_cnt, COL_W'(sat_bump(64'(line_pos), COL_W)),
                 {OFF_W{1'b0}}, {COL_W{1'b0}}, 1'b0};
    endfunction

    // advance the scanner by one beat and queue the records it causes
    task automatic predict_beat(input logic act, input logic [7:0] ch);
        record_t run [2];
        int      n;
        logic    nl;
        n  = 0;
        nl = (ch == CHAR_NL);
        if (act == ACT_EOF) begin
            if (mode == SCAN_TOKEN) begin
                run[n] = token_record();
                n++;
            end
            run[n] = '{KIND_EOF, line_cnt, line_pos, {OFF_W{1'b0}}, {COL_W{1'b0}}, 1'b0};
            n++;
            mode = SCAN_BETWEEN;
        end else begin
            case (mode)
                SCAN_TOKEN: begin
                    if (blank_byte(ch)) begin
                        run[n] = token_record();
                        n++;
                        mode = SCAN_BETWEEN;
                        if (nl) begin
                            run[n] = eol_record();
                            n++;
                        end
                    end else begin
                        tok_len = COL_W'(sat_bump(64'(tok_len), COL_W));
                    end
                end
                SCAN_COMMENT: begin
                    if (nl) begin
                        run[n] = eol_record();
                        n++;
                        mode = SCAN_BETWEEN;
                    end
                end
                // between tokens, and the unused mode value
                default: begin
                    mode = SCAN_BETWEEN;
                    if (nl) begin
                        run[n] = eol_record();
                        n++;
                    end else if (blank_byte(ch)) begin
                        mode = SCAN_BETWEEN;
                    end else if (ch == CHAR_HASH) begin
                        mode = SCAN_COMMENT;
                    end else begin
                        tok_off = stream_pos;
                        tok_col = COL_W'(sat_bump(64'(line_pos), COL_W));
                        tok_len = COL_W'(1);
                        mode    = SCAN_TOKEN;
                    end
                end
            endcase
            stream_pos = OFF_W'(sat_bump(64'(stream_pos), OFF_W));
            if (nl) begin
                line_cnt = LINE_W'(sat_bump(64'(line_cnt), LINE_W));
                line_pos = '0;
            end else begin
                line_pos = COL_W'(sat_bump(64'(line_pos), COL_W));
            end
        end
        if (n > 0) begin
            run[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            expected_records.push_back(run[i]);
        end
    endtask

    // watch all three ports; results first: no record leaves in its own beat's cycle
    always @(posedge aclk) begin
        record_t exp_rec;
        record_t got_rec;
        if (!aresetn) begin
            first_line = 1'b1;
            mode       = SCAN_BETWEEN;
            line_cnt   = LINE_W'(1);
            line_pos   = '0;
            stream_pos = '0;
            tok_off    = '0;
            tok_col    = '0;
            tok_len    = '0;
            expected_records.delete();
        end else begin
            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got_rec = '{m_tuser, m_tdata[LINE_W-1:0], m_tdata[COL_LSB +: COL_W],
                            m_tdata[OFF_LSB +: OFF_W], m_tdata[LEN_LSB +: COL_W], m_tlast};
                if (expected_records.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display({"unexpected record: kind %0d line %0d col %0d",
                                  " off %0d len %0d last %0b"},
                                 got_rec.kind, got_rec.line, got_rec.col, got_rec.off,
                                 got_rec.len, got_rec.last);
                    end
                end else begin
                    exp_rec = expected_records.pop_front();
                    if (got_rec.kind !== exp_rec.kind || got_rec.line !== exp_rec.line ||
                        got_rec.col !== exp_rec.col || got_rec.off !== exp_rec.off ||
                        got_rec.len !== exp_rec.len || got_rec.last !== exp_rec.last) begin
                        errors++;
                        if (errors <= REPORT_MAX) begin
                            $display({"record mismatch: expected kind %0d line %0d",
                                      " col %0d off %0d len %0d last %0b"},
                                     exp_rec.kind, exp_rec.line, exp_rec.col, exp_rec.off,
                                     exp_rec.len, exp_rec.last);
                            $display({"                 actual   kind %0d line %0d",
                                      " col %0d off %0d len %0d last %0b"},
                                     got_rec.kind, got_rec.line, got_rec.col, got_rec.off,
                                     got_rec.len, got_rec.last);
                        end
                    end
                end
            end
            // register access phase
            if (psel && penable && pready && paddr[2] == REG_FIRST_LINE) begin
                if (pwrite) begin
                    first_line = pwdata[0];
                    if (stream_pos == '0) begin
                        line_cnt = {{(LINE_W-1){1'b0}}, first_line};
                    end
                end else if (prdata !== {31'b0, first_line}) begin
                    errors++;
                    if (errors <= REPORT_MAX) begin
                        $display("register read mismatch: expected %0h actual %0h",
                                 {31'b0, first_line}, prdata);
                    end
                end
            end
            // input beat
            if (s_tvalid && s_tready) begin
                predict_beat(s_tuser, s_tdata);
            end
        end
        pending    <= expected_records.size();
        fail_count <= errors;
    end

endmodule

>>> tb/whitespace_tokenizer_with_comments_unit_tb.sv
// testbench top: clock, reset, stimulus, watchdog and verdict for the tokenizer
`timescale 1ns / 1ps

module whitespace_tokenizer_with_comments_unit_tb;
    import wtc_pkg::*;

    localparam int TDATA_W =
        ((LINE_BITS_DEF + 2 * COLUMN_BITS_DEF + OFFSET_BITS_DEF + 7) / 8) * 8;

    localparam int QUIET_LIMIT      = 2000;
    localparam int IDLE_PCT         = 7;
    localparam int RANDOM_ITEMS     = 830;
    localparam int LONG_TOKEN_BYTES = 40;

    localparam logic [2:0] ADDR_FIRST_LINE = {REG_FIRST_LINE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED     = 3'b100;

    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;   // byte_in
    logic               s_tuser  = ACT_BYTE; // action
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;            // line_number, column, token_offset,
                                            // token_length, zero fill
    logic [1:0]         m_tuser;            // kind
    logic               m_tlast;            // last_of_run
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [2:0]         paddr    = 3'b000;
    logic [31:0]        pwdata   = 32'h0;
    logic [31:0]        prdata;
    logic               pready;

    int   pending;
    int   fail_count;
    logic steady      = 1'b0;
    int   quiet_count = 0;
    int   beats_sent  = 0;

    always #10 aclk = ~aclk;

    whitespace_tokenizer_with_comments_unit u_top (.*);

    whitespace_tokenizer_with_comments_unit_checker #(.TDATA_W(TDATA_W)) u_checker (.*);

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_count <= 0;
            end else if (quiet_count >= QUIET_LIMIT) begin
                $display("whitespace_tokenizer_with_comments_unit test failed");
                $finish;
            end else begin
                quiet_count <= quiet_count + 1;
            end
        end
    end

    // present one beat, with an occasional gap ahead of it
    task automatic send_beat(input logic act, input logic [7:0] ch);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) begin
            send_beat(ACT_BYTE, txt[i]);
        end
    endtask

    // stop sending until every predicted record is out, then let the block settle
    task automatic wait_drained(input int hold);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (hold) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_token_char(input bit allow_hash);
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(255));
        end while (is_space(c) || (!allow_hash && c == CHAR_HASH));
        return c;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(4))
            0:       return CHAR_SP;
            1:       return CHAR_TAB;
            2:       return CHAR_VT;
            3:       return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    initial begin
        int         base;
        int         cfg_stage;
        int         pick;
        int         n;
        logic [7:0] c;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first line number 0, seen on an end of file before any byte
        apb_access(1'b1, ADDR_FIRST_LINE, 32'hFFFF_FFFE);
        apb_access(1'b0, ADDR_FIRST_LINE, 32'h0);
        send_beat(ACT_EOF, 8'h00);
        wait_drained(8);
        apb_access(1'b1, ADDR_FIRST_LINE, 32'h0000_0001);
        apb_access(1'b1, ADDR_UNUSED, 32'h0);
        apb_access(1'b0, ADDR_FIRST_LINE, 32'h0);
        send_beat(ACT_EOF, 8'hFF);
        wait_drained(8);
        apb_access(1'b1, ADDR_FIRST_LINE, 32'h0);

        // newline ending a token, comment to newline, eof in token, in comment, between
        send_text("ab\n");
        send_text("#c#\n");
        send_text(" x");
        send_beat(ACT_EOF, 8'h00);
        send_text("\t#z");
        send_beat(ACT_EOF, 8'h00);
        send_beat(ACT_EOF, 8'h55);
        send_beat(ACT_BYTE, 8'hFF);
        send_beat(ACT_BYTE, 8'h80);
        send_text("a#b");
        send_beat(ACT_BYTE, CHAR_VT);
        send_beat(ACT_BYTE, CHAR_FF);
        send_beat(ACT_BYTE, CHAR_CR);
        send_beat(ACT_BYTE, CHAR_NL);

        // one longer token that may hold hashes after its first byte
        for (int i = 0; i < LONG_TOKEN_BYTES; i++) begin
            send_beat(ACT_BYTE, pick_token_char(i != 0));
        end
        send_text(" ab");
        send_beat(ACT_EOF, 8'h00);
        send_text("cd\n");

        // random text, mostly well-formed pieces
        base      = beats_sent;
        cfg_stage = 0;
        while (beats_sent - base < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                n = $urandom_range(1, 8);
                send_beat(ACT_BYTE, pick_token_char(1'b0));
                for (int i = 1; i < n; i++) begin
                    send_beat(ACT_BYTE, pick_token_char(1'b1));
                end
            end else if (pick < 65) begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    send_beat(ACT_BYTE, pick_blank());
                end
            end else if (pick < 75) begin
                send_beat(ACT_BYTE, CHAR_NL);
            end else if (pick < 85) begin
                send_beat(ACT_BYTE, CHAR_HASH);
                n = $urandom_range(0, 6);
                for (int i = 0; i < n; i++) begin
                    do begin
                        c = 8'($urandom_range(255));
                    end while (c == CHAR_NL);
                    send_beat(ACT_BYTE, c);
                end
                send_beat(ACT_BYTE, CHAR_NL);
            end else if (pick < 88) begin
                send_beat(ACT_EOF, 8'($urandom_range(255)));
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    send_beat(ACT_BYTE, 8'($urandom_range(255)));
                end
            end

            // register changes between phases, once the block is idle
            if (cfg_stage == 0 && beats_sent - base >= 300) begin
                wait_drained(8);
                apb_access(1'b1, ADDR_FIRST_LINE, 32'h0000_0001);
                apb_access(1'b0, ADDR_FIRST_LINE, 32'h0);
                cfg_stage = 1;
            end else if (cfg_stage == 1 && beats_sent - base >= 600) begin
                wait_drained(8);
                apb_access(1'b1, ADDR_FIRST_LINE, 32'h0);
                apb_access(1'b0, ADDR_FIRST_LINE, 32'h0);
                cfg_stage = 2;
            end else if ($urandom_range(79) == 0) begin
                wait_drained(2);
            end
            steady <= (beats_sent - base >= 420) && (beats_sent - base < 580);
        end

        // drain and verdict
        steady <= 1'b0;
        wait_drained(20);
        if (fail_count == 0) begin
            $display("whitespace_tokenizer_with_comments_unit test passed");
        end else begin
            $display("whitespace_tokenizer_with_comments_unit test failed");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/wtc_pkg.sv
hdl/wtc_scan.sv
hdl/wtc_fifo.sv
hdl/whitespace_tokenizer_with_comments_unit.sv
tb/whitespace_tokenizer_with_comments_unit_checker.sv
tb/whitespace_tokenizer_with_comments_unit_tb.sv
